>>> hw/rtl/bce_pkg.sv
// Shared types and constants for the backtracking choice enumerator.
// No dependencies; used by bce_stack_mem and backtracking_choice_enumerator.
package bce_pkg;

    // Fixed port widths of the payload fields
    localparam int unsigned FIELD_W = 16;
    localparam int unsigned MODE_W  = 2;

    // Item modes; the unused code falls to the default arm
    typedef enum logic [MODE_W-1:0] {
        MODE_BEGIN   = 2'd0,
        MODE_CHOOSE  = 2'd1,
        MODE_PREPARE = 2'd2
    } t_mode;

    // Sequencer states, one-hot
    typedef enum logic [2:0] {
        ST_IDLE     = 3'b001,
        ST_REPLAY   = 3'b010,
        ST_POP_CHK  = 3'b100
    } t_state;

    // Access strobes for the stack memory
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_ctl;

endpackage

>>> hw/rtl/backtracking_choice_enumerator.sv
// Depth-first enumerator of choice paths over a stack of choice points.
// Depends on bce_pkg and bce_stack_mem.
//
//  channel | valid        | stall        | payload
//  --------+--------------+--------------+------------------------------------------
//  input   | i_in_valid   | o_in_stall   | i_mode, i_option_count
//  output  | o_out_valid  | i_out_stall  | o_chosen_index, o_path_ready,
//          |              |              | o_cursor_error, o_stack_overflow
//
// Begin, push, overflow, cursor error, first-pass prepare and unused mode are
// answered in the next cycle. Replaying choose reads the stored option from the
// stack memory, then registers it. Prepare after the first pass examines entries
// from the top, one stack memory read per entry; an empty stack needs no read.
// Reset clears fill, cursor, state and control flags, not result or stack memory.
// A new transfer is taken only in idle with the result register free or draining.
module backtracking_choice_enumerator #(
    parameter int unsigned STACK_DEPTH  = 64,
    parameter int unsigned OPTION_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [bce_pkg::MODE_W-1:0]    i_mode,
    input  logic [bce_pkg::FIELD_W-1:0]   i_option_count,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [bce_pkg::FIELD_W-1:0]   o_chosen_index,
    output logic                          o_path_ready,
    output logic                          o_cursor_error,
    output logic                          o_stack_overflow
);

    localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int unsigned FW = $clog2(STACK_DEPTH + 1);
    localparam int unsigned OW = OPTION_WIDTH;
    localparam int unsigned EW = 2 * OW;

    // Control state
    bce_pkg::t_state r_state, n_state;
    logic [FW-1:0]   r_fill, n_fill;
    logic [FW-1:0]   r_cursor, n_cursor;
    logic            r_first, n_first;
    logic            r_out_valid, n_out_valid;

    // Result register
    logic [bce_pkg::FIELD_W-1:0] r_chosen, n_chosen;
    logic r_ready, n_ready;
    logic r_cerr, n_cerr;
    logic r_ovf, n_ovf;

    // Memory interface
    bce_pkg::t_mem_ctl mem_ctl;
    logic [AW-1:0]     wr_addr, rd_addr;
    logic [EW-1:0]     wr_data, rd_data;

    logic              accept;
    logic              out_free;
    bce_pkg::t_mode    mode;
    logic [OW-1:0]     cnt_in;
    logic [OW-1:0]     rd_cur, rd_cnt;
    logic [OW:0]       cur_next;
    logic              can_advance;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != bce_pkg::ST_IDLE) || !out_free;
    assign accept     = i_in_valid && !o_in_stall;
    assign mode       = bce_pkg::t_mode'(i_mode);
    assign cnt_in     = OW'(32'(i_option_count));

    // Entry layout: count in the upper half, current option in the lower
    assign rd_cur      = rd_data[OW-1:0];
    assign rd_cnt      = rd_data[EW-1:OW];
    assign cur_next    = {1'b0, rd_cur} + (OW+1)'(1);
    assign can_advance = {1'b0, rd_cnt} > cur_next;

    bce_stack_mem #(
        .DEPTH (STACK_DEPTH),
        .WIDTH (EW),
        .AW    (AW)
    ) u_stack (
        .i_clk     (i_clk),
        .i_ctl     (mem_ctl),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Sequence items through the stack
    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_cursor    = r_cursor;
        n_first     = r_first;
        n_out_valid = r_out_valid && i_out_stall;
        n_chosen    = r_chosen;
        n_ready     = r_ready;
        n_cerr      = r_cerr;
        n_ovf       = r_ovf;
        mem_ctl     = '0;
        wr_addr     = r_fill[AW-1:0];
        wr_data     = '0;
        rd_addr     = r_cursor[AW-1:0];

        unique case (r_state)
            bce_pkg::ST_IDLE: begin
                if (accept) begin
                    // Default answer is all zero; it is shown unless a stack read is started
                    n_chosen    = '0;
                    n_ready     = 1'b0;
                    n_cerr      = 1'b0;
                    n_ovf       = 1'b0;
                    n_out_valid = 1'b1;
                    unique case (mode)
                        bce_pkg::MODE_BEGIN: begin
                            n_first = 1'b1;
                        end
                        bce_pkg::MODE_CHOOSE: begin
                            priority if (r_cursor < r_fill) begin
                                // Replay the stored option after the read returns
                                mem_ctl.rd_en = 1'b1;
                                rd_addr       = r_cursor[AW-1:0];
                                n_out_valid   = 1'b0;
                                n_state       = bce_pkg::ST_REPLAY;
                            end else if (r_fill < FW'(STACK_DEPTH)) begin
                                // Push a fresh entry at option 0
                                mem_ctl.wr_en = 1'b1;
                                wr_addr       = r_fill[AW-1:0];
                                wr_data       = {cnt_in, OW'(0)};
                                n_fill        = r_fill + FW'(1);
                                n_cursor      = r_fill + FW'(1);
                            end else begin
                                n_ovf = 1'b1;
                            end
                        end
                        bce_pkg::MODE_PREPARE: begin
                            priority if (r_cursor != r_fill) begin
                                n_cerr = 1'b1;
                            end else if (r_first) begin
                                n_cursor = '0;
                                n_first  = 1'b0;
                                n_ready  = 1'b1;
                            end else if (r_fill == '0) begin
                                n_cursor = '0;
                            end else begin
                                // Start popping from the top entry
                                n_cursor      = '0;
                                mem_ctl.rd_en = 1'b1;
                                rd_addr       = AW'(r_fill - FW'(1));
                                n_out_valid   = 1'b0;
                                n_state       = bce_pkg::ST_POP_CHK;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            bce_pkg::ST_REPLAY: begin
                n_chosen    = bce_pkg::FIELD_W'(32'(rd_cur));
                n_cursor    = r_cursor + FW'(1);
                n_out_valid = 1'b1;
                n_state     = bce_pkg::ST_IDLE;
            end
            bce_pkg::ST_POP_CHK: begin
                priority if (can_advance) begin
                    // Advance the top entry and report a path
                    mem_ctl.wr_en = 1'b1;
                    wr_addr       = AW'(r_fill - FW'(1));
                    wr_data       = {rd_cnt, cur_next[OW-1:0]};
                    n_ready       = 1'b1;
                    n_out_valid   = 1'b1;
                    n_state       = bce_pkg::ST_IDLE;
                end else if (r_fill == FW'(1)) begin
                    // Last entry dropped: enumeration exhausted
                    n_fill      = '0;
                    n_out_valid = 1'b1;
                    n_state     = bce_pkg::ST_IDLE;
                end else begin
                    // Drop the exhausted top and read the one below
                    n_fill        = r_fill - FW'(1);
                    mem_ctl.rd_en = 1'b1;
                    rd_addr       = AW'(r_fill - FW'(2));
                end
            end
            default: begin
                n_state = bce_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bce_pkg::ST_IDLE;
            r_fill      <= '0;
            r_cursor    <= '0;
            r_first     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_cursor    <= n_cursor;
            r_first     <= n_first;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        r_chosen <= n_chosen;
        r_ready  <= n_ready;
        r_cerr   <= n_cerr;
        r_ovf    <= n_ovf;
    end

    assign o_out_valid      = r_out_valid;
    assign o_chosen_index   = r_chosen;
    assign o_path_ready     = r_ready;
    assign o_cursor_error   = r_cerr;
    assign o_stack_overflow = r_ovf;

endmodule

>>> hw/rtl/bce_stack_mem.sv
// Choice stack storage: one write port, one read port with registered data.
// Depends on bce_pkg for the access strobe struct.
module bce_stack_mem #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned WIDTH = 32,
    parameter int unsigned AW    = 6
) (
    input  logic               i_clk,
    input  bce_pkg::t_mem_ctl  i_ctl,
    input  logic [AW-1:0]      i_wr_addr,
    input  logic [WIDTH-1:0]   i_wr_data,
    input  logic [AW-1:0]      i_rd_addr,
    output logic [WIDTH-1:0]   o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write an entry
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read, updated only when a read is enabled
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
